FILE: rtl/packet_rule_classifier_macros.svh
// assertion macros for the packet rule classifier
// used by modules that assert; expects clk and arst_n in scope
`ifndef PACKET_RULE_CLASSIFIER_MACROS_SVH
`define PACKET_RULE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/prc_pkg.sv
// shared types, codes and constants of the packet rule classifier
// no dependencies
package prc_pkg;

	localparam int IDX_W        = 4;
	localparam int ACT_W        = 4;
	localparam int RESULT_LIMIT = 16;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_ICMP  = 8'd1;
	localparam logic [7:0]  IP_TCP   = 8'd6;
	localparam logic [7:0]  IP_UDP   = 8'd17;

	// bit positions in the wildcard flags
	localparam int WILD_ADDR = 0;
	localparam int WILD_PORT = 1;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_APPEND   = 2'd1,
		OP_CLASSIFY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PROTO_ANY  = 2'd0,
		PROTO_TCP  = 2'd1,
		PROTO_UDP  = 2'd2,
		PROTO_ICMP = 2'd3
	} proto_t;

	typedef struct packed {
		proto_t             protocol;
		logic [1:0]         wild;
		logic [31:0]        address;
		logic [15:0]        port;
		logic [ACT_W-1:0]   action;
	} rule_t;

	typedef struct packed {
		proto_t      proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] port;
	} pkt_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] index;
		logic [ACT_W-1:0] action;
	} slot_t;

	typedef struct packed {
		logic load;
		logic flush;
		logic take;
		logic give;
	} cell_ctl_t;

	// any means not classifiable here
	function automatic proto_t proto_code(input logic [7:0] ip_proto);
		proto_t code;
		unique case (ip_proto)
			IP_TCP:  code = PROTO_TCP;
			IP_UDP:  code = PROTO_UDP;
			IP_ICMP: code = PROTO_ICMP;
			default: code = PROTO_ANY;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/prc_cell.sv
// one cell of the classifier chain: holds one rule and one result slot
// depends on prc_pkg
module prc_cell
	import prc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic             wr_en,
	input  rule_t            wr_rule,
	input  logic             rule_en,
	input  pkt_t             pkt,
	input  cell_ctl_t        ctl,
	input  slot_t            nxt,
	output slot_t            slot
);

	rule_t            rule_q;
	logic             vld_q;
	logic [IDX_W-1:0] index_q;
	logic [ACT_W-1:0] action_q;
	logic             proto_ok;
	logic             addr_ok;
	logic             port_ok;
	logic             match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_q <= wr_rule;
		end
	end

	always_comb begin
		proto_ok = (rule_q.protocol == PROTO_ANY) || (rule_q.protocol == pkt.proto);
		addr_ok  = rule_q.wild[WILD_ADDR] || (rule_q.address == pkt.src) ||
			(rule_q.address == pkt.dst);
		port_ok  = rule_q.wild[WILD_PORT] || (rule_q.port == pkt.port);
		match    = rule_en && proto_ok && addr_ok && port_ok;
	end

	// slot is flushed, loads its own match, takes from the successor or hands on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			priority if (ctl.flush) begin
				vld_q <= 1'b0;
			end else if (ctl.load) begin
				vld_q <= match;
			end else if (ctl.take) begin
				vld_q <= nxt.vld;
			end else if (ctl.give) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			index_q  <= idx;
			action_q <= rule_q.action;
		end else if (ctl.take) begin
			index_q  <= nxt.index;
			action_q <= nxt.action;
		end
	end

	assign slot.vld    = vld_q;
	assign slot.index  = index_q;
	assign slot.action = action_q;

endmodule

FILE: rtl/packet_rule_classifier.sv
// Packet rule classifier. An item is taken when start is high and busy is low; op selects
// clear, append or classify. Clear and append finish at the edge that takes them and leave
// busy low. A classify item is registered, then every rule cell compares it against its
// rule at once and keeps a match flag; the flags then drain along the cell chain towards
// cell 0, which shows the results one at a time on result_valid. A flag moves one cell per
// cycle while the cell ahead of it is empty. Flags queued behind one another do not come
// out back to back, except matches in both of the first two cells, which do. Only an IPv4
// TCP, UDP or ICMP item is classified; any other leaves busy low. busy stays high from the
// cycle after a classified item up to the cycle of its last result, or only while the item
// is registered when nothing matches. result_valid lasts exactly one cycle per result and
// cannot be held off. At most 16 results are given per packet, the last flagged by
// last_match. Rule storage has no reset; only written rules take part.
// depends on prc_pkg, prc_cell and packet_rule_classifier_macros.svh
`include "packet_rule_classifier_macros.svh"

module packet_rule_classifier
	import prc_pkg::*;
#(
	parameter int MAX_RULES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [1:0]       rule_protocol,
	input  logic [1:0]       rule_wild,
	input  logic [31:0]      rule_address,
	input  logic [15:0]      rule_port,
	input  logic [ACT_W-1:0] rule_action,
	input  logic [15:0]      ether_type,
	input  logic [7:0]       ip_protocol,
	input  logic [31:0]      source_address,
	input  logic [31:0]      dest_address,
	input  logic [15:0]      dest_port,
	output logic             result_valid,
	output logic [IDX_W-1:0] matched_index,
	output logic [ACT_W-1:0] matched_action,
	output logic             last_match
);

	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(RESULT_LIMIT - 1);

	logic             accept;
	logic             do_clear;
	logic             do_append;
	logic             do_classify;
	logic             full;
	logic             pkt_ok;
	proto_t           in_code;
	rule_t            wr_rule;
	logic [CNT_W-1:0] rule_count_q;
	logic             pkt_vld_s1;
	pkt_t             pkt_s1;
	logic [IDX_W-1:0] emit_cnt_q;
	logic             rest_vld;
	logic             flush;

	slot_t                slots [MAX_RULES];
	logic [MAX_RULES-1:0] vld_vec;
	logic [MAX_RULES-1:0] take_vec;

	assign accept = start && !busy;
	assign full   = (rule_count_q == CNT_W'(MAX_RULES));

	always_comb begin
		do_clear    = 1'b0;
		do_append   = 1'b0;
		do_classify = 1'b0;
		if (accept) begin
			unique case (op)
				OP_CLEAR:    do_clear    = 1'b1;
				OP_APPEND:   do_append   = 1'b1;
				OP_CLASSIFY: do_classify = 1'b1;
				default:     ;
			endcase
		end
	end

	always_comb begin
		in_code          = proto_code(ip_protocol);
		pkt_ok           = do_classify && (ether_type == ETH_IPV4) && (in_code != PROTO_ANY);
		wr_rule.protocol = proto_t'(rule_protocol);
		wr_rule.wild     = rule_wild;
		wr_rule.address  = rule_address;
		wr_rule.port     = rule_port;
		wr_rule.action   = rule_action;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (do_clear) begin
			rule_count_q <= '0;
		end else if (do_append && !full) begin
			rule_count_q <= rule_count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_vld_s1 <= 1'b0;
		end else begin
			pkt_vld_s1 <= pkt_ok;
		end
	end

	// icmp carries no port, compare against zero
	always_ff @(posedge clk) begin
		if (pkt_ok) begin
			pkt_s1.proto <= in_code;
			pkt_s1.src   <= source_address;
			pkt_s1.dst   <= dest_address;
			pkt_s1.port  <= (in_code == PROTO_ICMP) ? 16'd0 : dest_port;
		end
	end

	genvar k;
	generate
		for (k = 0; k < MAX_RULES; k++) begin : g_cell
			slot_t     nxt;
			cell_ctl_t ctl;

			assign vld_vec[k]  = slots[k].vld;
			assign take_vec[k] = (k == 0) ? 1'b1 : !vld_vec[k];

			if (k == MAX_RULES - 1) begin : g_tail
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = slots[k+1];
			end

			always_comb begin
				ctl.load  = pkt_vld_s1;
				ctl.flush = flush;
				ctl.take  = take_vec[k];
				ctl.give  = (k == 0) ? 1'b0 : take_vec[(k == 0) ? 0 : k-1];
			end

			prc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IDX_W'(k)),
				.wr_en   (do_append && (rule_count_q == CNT_W'(k))),
				.wr_rule (wr_rule),
				.rule_en (CNT_W'(k) < rule_count_q),
				.pkt     (pkt_s1),
				.ctl     (ctl),
				.nxt     (nxt),
				.slot    (slots[k])
			);
		end
	endgenerate

	assign rest_vld       = |(vld_vec >> 1);
	assign result_valid   = vld_vec[0];
	assign matched_index  = slots[0].index;
	assign matched_action = slots[0].action;
	assign last_match     = vld_vec[0] && ((emit_cnt_q == LAST_CNT) || !rest_vld);
	// result limit reached or nothing left: drop whatever is still in the chain
	assign flush          = last_match;
	assign busy           = pkt_vld_s1 || (|vld_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
		end else if (last_match) begin
			emit_cnt_q <= '0;
		end else if (result_valid) begin
			emit_cnt_q <= emit_cnt_q + IDX_W'(1);
		end
	end

	`PRC_ASSERT_SAME(a_last_has_strobe, last_match, result_valid,
		"last_match without result")
	`PRC_ASSERT_NEXT(a_idle_after_last, last_match, !busy,
		"chain not empty after last result")
	`PRC_ASSERT_NEXT(a_more_after_mid, result_valid && !last_match, busy,
		"block idle before last result")
	`PRC_ASSERT_SAME(a_chain_empty_on_load, pkt_vld_s1, vld_vec == '0,
		"match flags loaded into a busy chain")
	`PRC_ASSERT_SAME(a_count_bound, 1'b1, rule_count_q <= CNT_W'(MAX_RULES),
		"rule count beyond table size")

endmodule
